/* rtl/page_frame_stack_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Page frame stack allocator assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PFSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PFSA_ASSERT_SAME(label, ante, cons)

`define PFSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/pfsa_pkg.sv */
// ----------------------------------------------------------------------------
// Page frame stack allocator package
// Shared widths, command codes, controller states and control struct.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  localparam int FRAME_COUNT_DEF = 64;
  localparam int FRAME_W         = 12;
  localparam int CMD_W           = 2;
  localparam int COUNT_W         = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } pfsa_cmd_code_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } pfsa_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } pfsa_ctl_t;

endpackage

/* rtl/pfsa_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfsa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pfsa_ctrl.sv */
// ----------------------------------------------------------------------------
// Page frame stack allocator controller
// Sequences capture and execute of one transaction and owns the result valid.
// ----------------------------------------------------------------------------
module pfsa_ctrl
  import pfsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pfsa_ctl_t ctl
);

  pfsa_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          ctl.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/pfsa_dpath.sv */
// ----------------------------------------------------------------------------
// Page frame stack allocator datapath
// Stack pointer, replaced bits, frame store and result registers.
// ----------------------------------------------------------------------------
module pfsa_dpath
  import pfsa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pfsa_ctl_t          ctl,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [FRAME_W-1:0] in_frame_in,
  output logic [FRAME_W-1:0] out_frame_out,
  output logic               out_ok,
  output logic [COUNT_W-1:0] out_allocated_count
);

  localparam int SPW   = $clog2(FRAME_COUNT + 1);
  localparam int AW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW    = (SPW > COUNT_W) ? SPW : COUNT_W;
  localparam int WIN_W = FRAME_W + 1;

  logic [FRAME_W-1:0]     base_r;
  logic [SPW-1:0]         sp_r, sp_nxt;
  logic [FRAME_COUNT-1:0] replaced_r, replaced_nxt;
  logic [CMD_W-1:0]       command_r;
  logic [FRAME_W-1:0]     frame_in_r;
  logic [FRAME_W-1:0]     frame_out_r, frame_out_nxt;
  logic                   ok_r, ok_nxt;
  logic [COUNT_W-1:0]     count_r;

  logic [AW-1:0]          rd_idx;
  logic [SPW-1:0]         sp_dec;
  logic [AW-1:0]          wr_idx;
  logic                   ram_we;
  logic [FRAME_W-1:0]     ram_rdata;
  logic [WIN_W-1:0]       win_end;
  logic                   in_win;
  logic [CW-1:0]          sp_ext;

  pfsa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (FRAME_COUNT),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (frame_in_r),
    .re    (ctl.capture),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign rd_idx  = sp_r[AW-1:0];
  assign sp_dec  = sp_r - SPW'(1);
  assign wr_idx  = sp_dec[AW-1:0];
  assign win_end = {1'b0, base_r} + WIN_W'(FRAME_COUNT);
  assign in_win  = (frame_in_r >= base_r) && ({1'b0, frame_in_r} < win_end);

  always_comb begin
    sp_nxt        = sp_r;
    replaced_nxt  = replaced_r;
    frame_out_nxt = '0;
    ok_nxt        = 1'b0;
    ram_we        = 1'b0;
    case (command_r)
      CMD_ALLOC: begin
        if (sp_r < SPW'(FRAME_COUNT)) begin
          frame_out_nxt = replaced_r[rd_idx] ? ram_rdata : base_r + FRAME_W'(rd_idx);
          sp_nxt        = sp_r + SPW'(1);
          ok_nxt        = 1'b1;
        end
      end
      CMD_FREE: begin
        if (sp_r != '0 && in_win) begin
          sp_nxt               = sp_dec;
          replaced_nxt[wr_idx] = 1'b1;
          ram_we               = ctl.execute;
          ok_nxt               = 1'b1;
        end
      end
      CMD_INIT: begin
        sp_nxt       = '0;
        replaced_nxt = '0;
        ok_nxt       = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  assign sp_ext = CW'(sp_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      sp_r       <= '0;
      replaced_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (ctl.execute) begin
        sp_r       <= sp_nxt;
        replaced_r <= replaced_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      command_r  <= in_command;
      frame_in_r <= in_frame_in;
    end
    if (ctl.execute) begin
      frame_out_r <= frame_out_nxt;
      ok_r        <= ok_nxt;
      count_r     <= sp_ext[COUNT_W-1:0];
    end
  end

  assign out_frame_out       = frame_out_r;
  assign out_ok              = ok_r;
  assign out_allocated_count = count_r;

endmodule

/* rtl/page_frame_stack_allocator.sv */
// ----------------------------------------------------------------------------
// Page frame stack allocator
// Allocates and frees page frames of a memory window as a stack of free frames.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one command per transaction:
//   allocate, free (in_frame_in is the frame returned) or reinitialize.
//   The result channel (out_valid/out_ready) returns one transaction per
//   command: the allocated frame, an ok flag and the allocated count.
//   cfg_wr_en/cfg_wr_data set the window's first frame; write it only while
//   no command is in flight.
//   The result is registered when the command executes, which waits for a free
//   output register. A new command is accepted only after the last one executes;
//   the frame store is read at capture and the pointer is updated at execute.
//   Reset: the stack pointer and base frame clear and every entry reads as
//   base plus its index; no clearing pass is needed.
//   Stall: a waiting result holds in the output register; the next command is
//   still accepted and finishes once the receiver takes the held result.
// ----------------------------------------------------------------------------
`include "page_frame_stack_allocator_macros.svh"

module page_frame_stack_allocator
  import pfsa_pkg::*;
#(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [FRAME_W-1:0] in_frame_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAME_W-1:0] out_frame_out,
  output logic               out_ok,
  output logic [COUNT_W-1:0] out_allocated_count
);

  pfsa_ctl_t ctl;

  pfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  pfsa_dpath #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_command          (in_command),
    .in_frame_in         (in_frame_in),
    .out_frame_out       (out_frame_out),
    .out_ok              (out_ok),
    .out_allocated_count (out_allocated_count)
  );

  `PFSA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `PFSA_ASSERT_SAME(a_frame_implies_ok, out_valid && (out_frame_out != '0), out_ok)
  `PFSA_ASSERT_SAME(a_count_in_range, out_valid, int'(out_allocated_count) <= FRAME_COUNT)

endmodule

/* verif/page_frame_stack_allocator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page frame stack allocator checker
// Watches the configuration, command and result channels, keeps its own copy
// of the free frame stack and window base, predicts each command's result and
// compares every returned transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_checker
  import pfsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [FRAME_W-1:0] in_frame_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [FRAME_W-1:0] out_frame_out,
  input  logic               out_ok,
  input  logic [COUNT_W-1:0] out_allocated_count,
  output int                 pending,
  output int                 mismatches
);

  localparam int SLOTS = FRAME_COUNT_DEF;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } frame_grant_t;

  frame_grant_t       grants_due[$];
  logic [FRAME_W-1:0] returned_frame[SLOTS];
  bit                 slot_returned[SLOTS];
  int                 stack_depth = 0;
  logic [FRAME_W-1:0] window_base = '0;
  int                 fail_total = 0;

  assign mismatches = fail_total;

  function automatic frame_grant_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [FRAME_W-1:0] frame);
    frame_grant_t grant;
    grant = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (stack_depth < SLOTS) begin
          grant.frame = slot_returned[stack_depth] ? returned_frame[stack_depth]
                                                   : window_base + FRAME_W'(stack_depth);
          stack_depth++;
          grant.ok = 1'b1;
        end
      end
      CMD_FREE: begin
        if (stack_depth > 0 && int'(frame) >= int'(window_base) &&
            int'(frame) < int'(window_base) + SLOTS) begin
          stack_depth--;
          returned_frame[stack_depth] = frame;
          slot_returned[stack_depth] = 1'b1;
          grant.ok = 1'b1;
        end
      end
      CMD_INIT: begin
        slot_returned = '{default: 1'b0};
        stack_depth = 0;
        grant.ok = 1'b1;
      end
      default: begin
      end
    endcase
    grant.count = COUNT_W'(stack_depth);
    return grant;
  endfunction

  always @(posedge clk) begin
    frame_grant_t want;
    if (!rst_n) begin
      grants_due.delete();
      slot_returned = '{default: 1'b0};
      stack_depth = 0;
      window_base = '0;
    end else begin
      if (cfg_wr_en) window_base = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result transaction: frame_out %0d ok %0d allocated_count %0d",
                 out_frame_out, out_ok, out_allocated_count);
          fail_total++;
        end else begin
          want = grants_due.pop_front();
          if (out_frame_out !== want.frame) begin
            $error("frame_out mismatch: expected %0d, actual %0d", want.frame, out_frame_out);
            fail_total++;
          end
          if (out_ok !== want.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", want.ok, out_ok);
            fail_total++;
          end
          if (out_allocated_count !== want.count) begin
            $error("allocated_count mismatch: expected %0d, actual %0d",
                   want.count, out_allocated_count);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) grants_due.push_back(apply_command(in_command, in_frame_in));
    end
    pending <= grants_due.size();
  end

endmodule

/* verif/page_frame_stack_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page frame stack allocator testbench
// Drives directed corner commands and then random phases, mostly allocate/free,
// over several window bases, with bursty command traffic and result backpressure.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_test;
  import pfsa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SLOTS       = FRAME_COUNT_DEF;
  localparam int FRAME_MAX   = (1 << FRAME_W) - 1;

  typedef enum int {RX_STEADY, RX_JITTER, RX_SLOW} rx_pattern_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [FRAME_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   in_command = CMD_ALLOC;
  logic [FRAME_W-1:0] in_frame_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FRAME_W-1:0] out_frame_out;
  logic               out_ok;
  logic [COUNT_W-1:0] out_allocated_count;
  int                 pending;
  int                 mismatches;

  int                 cycle_count = 0;
  int                 commands_sent = 0;
  int                 base_writes = 0;
  int                 burst_left = 0;
  int                 rx_hold = 0;
  rx_pattern_t        rx_pattern = RX_STEADY;
  logic [FRAME_W-1:0] window_base = '0;

  page_frame_stack_allocator u_top (.*);

  page_frame_stack_allocator_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 2));
      rx_hold = $urandom_range(20, 80);
    end else begin
      rx_hold--;
    end
    case (rx_pattern)
      RX_STEADY: out_ready <= 1'b1;
      RX_JITTER: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 9) == 0) ? ~out_ready : out_ready;
    endcase
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] frame);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_frame_in <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
  endtask

  // hold off until every outstanding result has returned
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(input logic [FRAME_W-1:0] base);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_base = base;
    base_writes++;
  endtask

  function automatic logic [FRAME_W-1:0] release_frame();
    int roll;
    int base;
    int span;
    roll = $urandom_range(0, 99);
    base = window_base;
    span = (FRAME_MAX - base < SLOTS - 1) ? FRAME_MAX - base : SLOTS - 1;
    if (roll < 75) return FRAME_W'(base + $urandom_range(0, span));
    if (roll < 82) return (base == 0) ? FRAME_W'(FRAME_MAX) : FRAME_W'(base - 1);
    if (roll < 89) begin
      return (base + SLOTS <= FRAME_MAX) ? FRAME_W'(base + SLOTS)
                                         : FRAME_W'($urandom_range(0, base - 1));
    end
    return FRAME_W'($urandom);
  endfunction

  task automatic run_phase(input logic [FRAME_W-1:0] base, input int alloc_pct,
                           input int free_pct, input int count);
    int roll;
    settle();
    set_base(base);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) issue(CMD_ALLOC, FRAME_W'($urandom));
      else if (roll < alloc_pct + free_pct) issue(CMD_FREE, release_frame());
      else if (roll < 99) issue(CMD_INIT, FRAME_W'($urandom));
      else issue(CMD_RESERVED, FRAME_W'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_base('0);

    issue(CMD_FREE, 12'd0);
    issue(CMD_ALLOC, 12'hABC);
    issue(CMD_FREE, 12'd63);
    issue(CMD_ALLOC, 12'd0);
    issue(CMD_FREE, 12'd64);
    issue(CMD_RESERVED, 12'd5);
    issue(CMD_ALLOC, 12'd0);
    issue(CMD_INIT, 12'd0);
    issue(CMD_ALLOC, 12'd0);
    issue(CMD_FREE, 12'hFFF);
    issue(CMD_FREE, 12'd0);

    settle();
    set_base(12'hFFF);
    issue(CMD_ALLOC, 12'd0);
    issue(CMD_ALLOC, 12'hFFF);
    issue(CMD_FREE, 12'hFFE);
    issue(CMD_FREE, 12'hFFF);
    issue(CMD_ALLOC, 12'd0);
    issue(CMD_FREE, 12'd0);
    issue(CMD_INIT, 12'd0);

    run_phase(12'd4032, 95, 4, 80);
    run_phase(12'hFFF, 10, 88, 60);
    run_phase(FRAME_W'($urandom), 50, 47, 60);
    run_phase(12'd0, 95, 4, 80);
    run_phase(12'd4090, 15, 83, 80);
    run_phase(FRAME_W'($urandom), 45, 52, 60);

    settle();
    repeat (8) @(posedge clk);
    $display("Ran %0d commands (allocate, free, reinitialize, unused code) over %0d base writes,",
             commands_sent, base_writes);
    $display("filling and draining the frame stack under bursty input and output stalls.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
